// ===== rtl/core/c3rb_pkg.sv =====
// Shared types, register codes and constants of the 3x3 replicate-border convolution.
`default_nettype none

package c3rb_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int KERNEL        = 3;
  localparam int TAPS          = KERNEL * KERNEL;

  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 64;
  localparam int IMG_WIDTH_W  = 11;
  localparam int IMG_HEIGHT_W = 16;
  localparam int SAMPLE_W     = 16;
  localparam int COEFF_W      = 16;
  localparam int RESULT_W     = 24;
  localparam int ROW_W        = 16;
  localparam int OUT_COL_W    = 10;

  localparam int RST_IMAGE_WIDTH  = 1024;
  localparam int RST_IMAGE_HEIGHT = 1024;

  // Q8.8 times Q4.12 gives Q12.20; the result is Q16.8.
  localparam int FRAC_SHIFT = 12;
  localparam int ROUND_BIAS = 2048;
  localparam int PROD_W     = SAMPLE_W + COEFF_W;
  localparam int SUM3_W     = PROD_W + 2;
  localparam int ACC_W      = PROD_W + 4;
  localparam int SAT_MAX    = 8388607;
  localparam int SAT_MIN    = -8388608;

  localparam int RES_FIFO_DEPTH = 8;
  localparam int RES_FIFO_AW    = $clog2(RES_FIFO_DEPTH);
  localparam int RES_FIFO_CW    = $clog2(RES_FIFO_DEPTH + 1);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_COEFFS_LOW   = 3'd2,
    REG_COEFFS_MID   = 3'd3,
    REG_COEFF_LAST   = 3'd4
  } cfg_reg_t;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEFF_W-1:0]  coeff_t;

  typedef struct packed {
    logic [ROW_W-1:0]     row;
    logic [OUT_COL_W-1:0] col;
    logic                 last;
  } res_tag_t;

  typedef struct packed {
    logic signed [RESULT_W-1:0] value;
    res_tag_t                   tag;
  } result_t;

  // One line-store entry: the previous row and the row before it at one column.
  typedef struct packed {
    sample_t older;
    sample_t prev;
  } line_pair_t;

endpackage

`default_nettype wire

// ===== rtl/core/c3rb_line_mem.sv =====
// Line store: one synchronous RAM holding the two previous rows, with write-to-read bypass.
`default_nettype none

module c3rb_line_mem
  import c3rb_pkg::*;
#(
  parameter int DEPTH = MAX_WIDTH_DEF,
  parameter int AW    = 10
) (
  input  logic       clk,
  input  logic       rd_en,
  input  logic [AW-1:0] rd_addr,
  input  logic       wr_en,
  input  logic [AW-1:0] wr_addr,
  input  line_pair_t wr_data,
  output line_pair_t rd_data
);

  line_pair_t mem [DEPTH];
  line_pair_t rd_q;
  line_pair_t byp_q;
  logic       byp_hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // A write to the entry being read in the same cycle is returned in place of the old data.
    if (rd_en) begin
      rd_q    <= mem[rd_addr];
      byp_q   <= wr_data;
      byp_hit <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = byp_hit ? byp_q : rd_q;

endmodule

`default_nettype wire

// ===== rtl/core/c3rb_mac.sv =====
// Shared nine-tap multiply, add, round and saturate pipeline: one result per cycle.
`default_nettype none

module c3rb_mac
  import c3rb_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     job_valid,
  input  sample_t  job_px [TAPS],
  input  coeff_t   taps [TAPS],
  input  res_tag_t job_tag,
  output logic     res_valid,
  output result_t  res
);

  logic                     v1, v2, v3;
  logic signed [PROD_W-1:0] prod [TAPS];
  logic signed [SUM3_W-1:0] sum3 [KERNEL];
  logic signed [ACC_W-1:0]  total;
  logic signed [ACC_W-1:0]  shifted;
  logic signed [RESULT_W-1:0] sat_value;
  res_tag_t                 tag1, tag2, tag3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      v1        <= job_valid;
      v2        <= v1;
      v3        <= v2;
      res_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < TAPS; i++) begin
      prod[i] <= job_px[i] * taps[i];
    end
    tag1 <= job_tag;
    for (int j = 0; j < KERNEL; j++) begin
      sum3[j] <= SUM3_W'(prod[3*j]) + SUM3_W'(prod[3*j+1]) + SUM3_W'(prod[3*j+2]);
    end
    tag2 <= tag1;
    total <= ACC_W'(sum3[0]) + ACC_W'(sum3[1]) + ACC_W'(sum3[2]) + ACC_W'(ROUND_BIAS);
    tag3  <= tag2;
    res.value <= sat_value;
    res.tag   <= tag3;
  end

  // The bias is already in the sum, so the arithmetic shift rounds half up.
  always_comb begin
    shifted = total >>> FRAC_SHIFT;
    if (shifted > ACC_W'(SAT_MAX)) begin
      sat_value = RESULT_W'(SAT_MAX);
    end else if (shifted < ACC_W'(SAT_MIN)) begin
      sat_value = RESULT_W'(SAT_MIN);
    end else begin
      sat_value = shifted[RESULT_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/c3rb_out_fifo.sv =====
// Result queue between the multiply pipeline and the output channel.
`default_nettype none

module c3rb_out_fifo
  import c3rb_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t din,
  input  logic    pop,
  output logic    valid,
  output result_t dout
);

  result_t                 slots [RES_FIFO_DEPTH];
  logic [RES_FIFO_AW-1:0]  wr_ptr;
  logic [RES_FIFO_AW-1:0]  rd_ptr;
  logic [RES_FIFO_CW-1:0]  count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign valid = (count != '0);
  assign dout  = slots[rd_ptr];

endmodule

`default_nettype wire

// ===== rtl/core/conv3x3_replicate_border_core.sv =====
// Streaming 3x3 convolution with replicate padding: line store, window, job issue and output.
//
// Pixels enter in raster order on in_valid/in_ready as signed Q8.8 values; results leave on
// out_valid/out_ready with their row, column and an end-of-image flag. Register writes come
// on cfg_valid/cfg_ready (always ready) with a register index and data; the user must make
// them only while idle, which the block does not enforce. Results for row r-1 are produced
// while row r streams in; the last row's results come out with the last row itself. An item
// that completes a window gives its first result after the line-store read, window update
// and multiply pipeline. Each item makes zero to four results: one in the body of the image,
// two on the last row, up to four at the last column. The nine multipliers are shared and
// deliver one result per cycle, so while the output keeps up the block takes one pixel per
// cycle while each pixel makes at most one result, and otherwise one pixel per result. An
// eight-entry result queue with a credit count decouples the output: input transfers continue
// while results wait, until the queue and the pipeline hold eight results. Reset clears the
// position, the window, the pipeline and the queue and restores width 1024, height 1024 and
// zero taps. The line store is not cleared; every entry is written before use in an image.
`default_nettype none

module conv3x3_replicate_border_core
  import c3rb_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] pixel_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [RESULT_W-1:0] filtered_value,
  output logic [ROW_W-1:0]           out_row,
  output logic [OUT_COL_W-1:0]       out_col,
  output logic                       last_of_image
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = ($clog2(MAX_WIDTH + 1) > IMG_WIDTH_W) ? $clog2(MAX_WIDTH + 1)
                                                           : IMG_WIDTH_W;

  // Result kinds of one item, in the order they leave.
  localparam int JOB_PREV_ROW  = 0;
  localparam int JOB_PREV_EDGE = 1;
  localparam int JOB_LAST_ROW  = 2;
  localparam int JOB_LAST_EDGE = 3;

  // Configuration registers
  logic [IMG_WIDTH_W-1:0]  image_width;
  logic [IMG_HEIGHT_W-1:0] image_height;
  logic [CFG_DATA_W-1:0]   coeffs_low_four;
  logic [CFG_DATA_W-1:0]   coeffs_mid_four;
  coeff_t                  coeff_last;

  logic [WW-1:0]           width_ext;
  logic [WW-1:0]           width_last;
  logic [IMG_HEIGHT_W-1:0] height_last;
  coeff_t                  taps [TAPS];

  // Position of the next input pixel
  logic [ROW_W-1:0] row_pos;
  logic [CW-1:0]    col_pos;
  logic             lastcol;
  logic             lastrow;
  logic             in_xfer;

  // Stage 1: pixel waiting for its line-store data
  logic             s1_valid;
  sample_t          s1_pixel;
  logic [ROW_W-1:0] s1_row;
  logic [CW-1:0]    s1_col;
  logic             s1_lastcol;
  logic             s1_lastrow;
  logic             s1_adv;
  logic             s1_row_zero;
  logic             s1_row_one;
  logic             s1_col_zero;
  line_pair_t       rd_pair;
  line_pair_t       wr_pair;
  sample_t          vec [KERNEL];

  sample_t          win [KERNEL][KERNEL];

  // Stage 2: results still to issue for the item whose window is current
  logic [3:0]       s2_mask;
  logic [3:0]       mask_after;
  logic [3:0]       job_sel;
  logic [ROW_W-1:0] s2_row;
  logic [CW-1:0]    s2_col;
  logic             s2_free;
  logic             job_fire;
  logic             shift_c;
  logic             shift_r;
  sample_t          job_px [TAPS];
  res_tag_t         job_tag;
  logic [CW-1:0]    job_col;
  logic [CW+OUT_COL_W-1:0] job_col_wide;

  logic [RES_FIFO_CW-1:0] inflight;
  logic                   out_xfer;
  logic                   res_valid;
  result_t                res;
  result_t                head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= IMG_WIDTH_W'(RST_IMAGE_WIDTH);
      image_height    <= IMG_HEIGHT_W'(RST_IMAGE_HEIGHT);
      coeffs_low_four <= '0;
      coeffs_mid_four <= '0;
      coeff_last      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width     <= cfg_data[IMG_WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: image_height    <= cfg_data[IMG_HEIGHT_W-1:0];
        REG_COEFFS_LOW:   coeffs_low_four <= cfg_data;
        REG_COEFFS_MID:   coeffs_mid_four <= cfg_data;
        REG_COEFF_LAST:   coeff_last      <= cfg_data[COEFF_W-1:0];
        default: ;
      endcase
    end
  end

  // A width of zero acts as one, and a width beyond the line store as the full store.
  assign width_ext = WW'(image_width);
  always_comb begin
    if (image_width == '0) begin
      width_last = '0;
    end else if (width_ext > WW'(MAX_WIDTH)) begin
      width_last = WW'(MAX_WIDTH - 1);
    end else begin
      width_last = width_ext - 1'b1;
    end
  end

  assign height_last = (image_height == '0) ? '0 : image_height - 1'b1;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      taps[k]     = coeffs_low_four[COEFF_W*k +: COEFF_W];
      taps[k + 4] = coeffs_mid_four[COEFF_W*k +: COEFF_W];
    end
    taps[TAPS-1] = coeff_last;
  end

  assign lastcol = WW'(col_pos) >= width_last;
  assign lastrow = row_pos >= height_last;
  assign in_ready = !s1_valid || s1_adv;
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos <= '0;
      col_pos <= '0;
    end else if (in_xfer) begin
      if (lastcol) begin
        col_pos <= '0;
        row_pos <= lastrow ? '0 : row_pos + 1'b1;
      end else begin
        col_pos <= col_pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_pixel   <= pixel_value;
      s1_row     <= row_pos;
      s1_col     <= col_pos;
      s1_lastcol <= lastcol;
      s1_lastrow <= lastrow;
    end
  end

  c3rb_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (in_xfer),
    .rd_addr (col_pos),
    .wr_en   (s1_adv),
    .wr_addr (s1_col),
    .wr_data (wr_pair),
    .rd_data (rd_pair)
  );

  assign s1_row_zero = (s1_row == '0);
  assign s1_row_one  = (s1_row == ROW_W'(1));
  assign s1_col_zero = (s1_col == '0);
  assign s1_adv      = s1_valid && s2_free;

  // Column vector top to bottom; rows above the image repeat the top row.
  always_comb begin
    if (s1_row_zero) begin
      vec[0] = s1_pixel;
      vec[1] = s1_pixel;
    end else if (s1_row_one) begin
      vec[0] = rd_pair.prev;
      vec[1] = rd_pair.prev;
    end else begin
      vec[0] = rd_pair.older;
      vec[1] = rd_pair.prev;
    end
    vec[2] = s1_pixel;
  end

  assign wr_pair.older = rd_pair.prev;
  assign wr_pair.prev  = s1_pixel;

  // The first column of a row fills all three window columns with the same vector.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < KERNEL; s++) begin
        for (int k = 0; k < KERNEL; k++) begin
          win[s][k] <= '0;
        end
      end
    end else if (s1_adv) begin
      for (int k = 0; k < KERNEL; k++) begin
        if (s1_col_zero) begin
          for (int s = 0; s < KERNEL; s++) begin
            win[s][k] <= vec[k];
          end
        end else begin
          for (int s = 0; s < KERNEL - 1; s++) begin
            win[s][k] <= win[s + 1][k];
          end
          win[KERNEL-1][k] <= vec[k];
        end
      end
    end
  end

  assign mask_after = s2_mask & (s2_mask - 1'b1);
  assign job_sel    = s2_mask & (~s2_mask + 1'b1);
  assign job_fire   = (s2_mask != '0) && (inflight != RES_FIFO_CW'(RES_FIFO_DEPTH));
  assign s2_free    = (s2_mask == '0) || (job_fire && (mask_after == '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_mask <= '0;
    end else if (s1_adv) begin
      s2_mask[JOB_PREV_ROW]  <= !s1_row_zero && !s1_col_zero;
      s2_mask[JOB_PREV_EDGE] <= !s1_row_zero && s1_lastcol;
      s2_mask[JOB_LAST_ROW]  <= s1_lastrow && !s1_col_zero;
      s2_mask[JOB_LAST_EDGE] <= s1_lastrow && s1_lastcol;
    end else if (job_fire) begin
      s2_mask <= mask_after;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_row <= s1_row;
      s2_col <= s1_col;
    end
  end

  // Edge results repeat the right column; last-row results repeat the bottom row.
  assign shift_c = job_sel[JOB_PREV_EDGE] || job_sel[JOB_LAST_EDGE];
  assign shift_r = job_sel[JOB_LAST_ROW] || job_sel[JOB_LAST_EDGE];

  always_comb begin
    logic [1:0] sx;
    logic [1:0] ry;
    for (int y = 0; y < KERNEL; y++) begin
      for (int x = 0; x < KERNEL; x++) begin
        if (shift_c && (x < KERNEL - 1)) begin
          sx = 2'(x + 1);
        end else begin
          sx = 2'(x);
        end
        if (shift_r && (y < KERNEL - 1)) begin
          ry = 2'(y + 1);
        end else begin
          ry = 2'(y);
        end
        job_px[KERNEL*y + x] = win[sx][ry];
      end
    end
  end

  assign job_col      = (job_sel[JOB_PREV_ROW] || job_sel[JOB_LAST_ROW]) ? s2_col - 1'b1
                                                                           : s2_col;
  assign job_col_wide = {{OUT_COL_W{1'b0}}, job_col};

  always_comb begin
    job_tag.row  = (job_sel[JOB_PREV_ROW] || job_sel[JOB_PREV_EDGE]) ? s2_row - 1'b1
                                                                      : s2_row;
    job_tag.col  = job_col_wide[OUT_COL_W-1:0];
    job_tag.last = job_sel[JOB_LAST_EDGE];
  end

  c3rb_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_fire),
    .job_px    (job_px),
    .taps      (taps),
    .job_tag   (job_tag),
    .res_valid (res_valid),
    .res       (res)
  );

  // Counts results issued and not yet transferred, so the queue can never overflow.
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      case ({job_fire, out_xfer})
        2'b10:   inflight <= inflight + 1'b1;
        2'b01:   inflight <= inflight - 1'b1;
        default: inflight <= inflight;
      endcase
    end
  end

  c3rb_out_fifo u_out_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (res_valid),
    .din   (res),
    .pop   (out_xfer),
    .valid (out_valid),
    .dout  (head)
  );

  assign out_xfer       = out_valid && out_ready;
  assign filtered_value = head.value;
  assign out_row        = head.tag.row;
  assign out_col        = head.tag.col;
  assign last_of_image  = head.tag.last;

endmodule

`default_nettype wire

// ===== rtl/core/c3rb_checker.sv =====
// Port-level checks on the convolution core, bound to its top level.
`default_nettype none

module c3rb_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] filtered_value,
  input logic [15:0] out_row,
  input logic [9:0]  out_col,
  input logic        last_of_image
);

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(filtered_value) && $stable(out_row)
                                && $stable(out_col) && $stable(last_of_image))
    else $error("stalled result changed or dropped");

  // Reset empties the pipeline and opens the input.
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && in_ready)
    else $error("block not idle after reset");

  // No result can reach the output in the cycle after reset ends.
  a_no_early_result: assert property (@(posedge clk)
    $past(rst) |=> !out_valid)
    else $error("result appeared too soon after reset");

endmodule

bind conv3x3_replicate_border_core c3rb_checker u_c3rb_checker (.*);

`default_nettype wire

// ===== dv/conv3x3_result_checker.sv =====
// Checker for the 3x3 replicate-border convolution: predicts each result and compares it.
module conv3x3_result_checker
  import c3rb_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [CFG_INDEX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] pixel_value,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic signed [RESULT_W-1:0] filtered_value,
  input  logic [ROW_W-1:0]           out_row,
  input  logic [OUT_COL_W-1:0]       out_col,
  input  logic                       last_of_image,
  output int                         mismatches,
  output int                         results_due,
  output logic                       at_image_start
);

  localparam int LINE_LEN = MAX_WIDTH_DEF;

  logic [IMG_WIDTH_W-1:0]  width_reg;
  logic [IMG_HEIGHT_W-1:0] height_reg;
  logic [CFG_DATA_W-1:0]   taps_low;
  logic [CFG_DATA_W-1:0]   taps_mid;
  coeff_t                  tap_last;

  // Lower half holds the previous row, upper half the row before it.
  sample_t     line_mem [2*LINE_LEN];
  // Entry slot*3 + k: slot 0 is the oldest column, k selects top, middle, bottom.
  sample_t     win [TAPS];
  int unsigned row_pos;
  int unsigned col_pos;
  result_t     pending_pixels [$];

  function automatic coeff_t tap_of(int k);
    if (k < 4) begin
      return coeff_t'(taps_low[16*k +: 16]);
    end
    if (k < 8) begin
      return coeff_t'(taps_mid[16*(k-4) +: 16]);
    end
    return tap_last;
  endfunction

  function automatic logic signed [RESULT_W-1:0] window_sum(int s0, int s1, int s2,
                                                            int r0, int r1, int r2);
    int     slot [3];
    int     rsel [3];
    longint acc;
    slot[0] = s0;
    slot[1] = s1;
    slot[2] = s2;
    rsel[0] = r0;
    rsel[1] = r1;
    rsel[2] = r2;
    acc = 0;
    for (int y = 0; y < 3; y++) begin
      for (int x = 0; x < 3; x++) begin
        acc += longint'(win[slot[x]*3 + rsel[y]]) * longint'(tap_of(3*y + x));
      end
    end
    // Arithmetic shift floors, so adding half first rounds ties upward.
    acc = (acc + ROUND_BIAS) >>> FRAC_SHIFT;
    if (acc > SAT_MAX) begin
      acc = SAT_MAX;
    end
    if (acc < SAT_MIN) begin
      acc = SAT_MIN;
    end
    return acc[RESULT_W-1:0];
  endfunction

  task automatic queue_result(int s0, int s1, int s2, int r0, int r1, int r2,
                              int unsigned row, int unsigned col, logic last);
    result_t res;
    res.value    = window_sum(s0, s1, s2, r0, r1, r2);
    res.tag.row  = row[ROW_W-1:0];
    res.tag.col  = col[OUT_COL_W-1:0];
    res.tag.last = last;
    pending_pixels.push_back(res);
  endtask

  task automatic convolve_pixel(sample_t p);
    int unsigned w;
    int unsigned h;
    int unsigned r;
    int unsigned c;
    sample_t     a;
    sample_t     b;
    sample_t     v [3];
    logic        lastcol;
    logic        lastrow;
    w = width_reg;
    if (w == 0) begin
      w = 1;
    end
    if (w > LINE_LEN) begin
      w = LINE_LEN;
    end
    h = height_reg;
    if (h == 0) begin
      h = 1;
    end
    r = row_pos;
    c = col_pos;
    if (c >= LINE_LEN) begin
      c = LINE_LEN - 1;
    end
    a = line_mem[c];
    b = line_mem[LINE_LEN + c];
    // Rows above the image replicate the nearest real row.
    if (r == 0) begin
      v[0] = p;
      v[1] = p;
    end else if (r == 1) begin
      v[0] = a;
      v[1] = a;
    end else begin
      v[0] = b;
      v[1] = a;
    end
    v[2] = p;
    line_mem[LINE_LEN + c] = a;
    line_mem[c]            = p;
    // The first column fills all three slots, which replicates the left border.
    if (c == 0) begin
      for (int k = 0; k < TAPS; k++) begin
        win[k] = v[k % 3];
      end
    end else begin
      for (int k = 0; k < 6; k++) begin
        win[k] = win[k + 3];
      end
      for (int k = 0; k < 3; k++) begin
        win[6 + k] = v[k];
      end
    end
    lastcol = (c >= w - 1);
    lastrow = (r >= h - 1);
    if (r >= 1) begin
      if (c >= 1) begin
        queue_result(0, 1, 2, 0, 1, 2, r - 1, c - 1, 1'b0);
      end
      if (lastcol) begin
        queue_result(1, 2, 2, 0, 1, 2, r - 1, c, 1'b0);
      end
    end
    // The padded row below the last one is a copy of it.
    if (lastrow) begin
      if (c >= 1) begin
        queue_result(0, 1, 2, 1, 2, 2, r, c - 1, 1'b0);
      end
      if (lastcol) begin
        queue_result(1, 2, 2, 1, 2, 2, r, c, 1'b1);
      end
    end
    if (lastcol) begin
      col_pos = 0;
      row_pos = lastrow ? 0 : ((r + 1) & 32'hFFFF);
    end else begin
      col_pos = c + 1;
    end
  endtask

  task automatic compare_result();
    result_t want;
    if (pending_pixels.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("unexpected result: value %0d row %0d col %0d last %0b",
                 filtered_value, out_row, out_col, last_of_image);
      end
    end else begin
      want = pending_pixels.pop_front();
      if (want.value !== filtered_value || want.tag.row !== out_row ||
          want.tag.col !== out_col || want.tag.last !== last_of_image) begin
        mismatches++;
        if (mismatches <= 10) begin
          // Fields are value/row/col/last.
          $display("result mismatch: expected %0d/%0d/%0d/%0b, actual %0d/%0d/%0d/%0b",
                   want.value, want.tag.row, want.tag.col, want.tag.last,
                   filtered_value, out_row, out_col, last_of_image);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_reg  = IMG_WIDTH_W'(RST_IMAGE_WIDTH);
      height_reg = IMG_HEIGHT_W'(RST_IMAGE_HEIGHT);
      taps_low   = '0;
      taps_mid   = '0;
      tap_last   = '0;
      for (int k = 0; k < 2*LINE_LEN; k++) begin
        line_mem[k] = '0;
      end
      for (int k = 0; k < TAPS; k++) begin
        win[k] = '0;
      end
      row_pos = 0;
      col_pos = 0;
      pending_pixels.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  width_reg  = cfg_data[IMG_WIDTH_W-1:0];
          REG_IMAGE_HEIGHT: height_reg = cfg_data[IMG_HEIGHT_W-1:0];
          REG_COEFFS_LOW:   taps_low   = cfg_data;
          REG_COEFFS_MID:   taps_mid   = cfg_data;
          REG_COEFF_LAST:   tap_last   = coeff_t'(cfg_data[COEFF_W-1:0]);
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        convolve_pixel(pixel_value);
      end
      if (out_valid && out_ready) begin
        compare_result();
      end
    end
    results_due    = pending_pixels.size();
    at_image_start = (row_pos == 0 && col_pos == 0);
  end

endmodule

// ===== dv/tb_conv3x3_replicate_border_core.sv =====
// Testbench top for the 3x3 replicate-border convolution: stimulus, flow control and verdict.
module tb_conv3x3_replicate_border_core;
  import c3rb_pkg::*;

  typedef coeff_t kernel_t [TAPS];
  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_COIN,
    RX_STALL_RUNS,
    RX_ONE_IN_FOUR
  } rx_mode_t;

  localparam logic [CFG_INDEX_W-1:0] SPARE_REG_INDEX = 3'd7;
  localparam coeff_t  TAP_ONE  = 16'sh1000;
  localparam coeff_t  TAP_HALF = 16'sh0800;
  localparam coeff_t  TAP_MAX  = 16'sh7FFF;
  localparam coeff_t  TAP_MIN  = 16'sh8000;
  localparam sample_t PIX_MAX  = 16'sh7FFF;
  localparam sample_t PIX_MIN  = 16'sh8000;
  localparam int      RANDOM_PIXELS = 230;
  localparam int      DRAIN_CYCLES  = 12;
  localparam int      WIDE_ROW_PIXELS = 20;

  logic                       clk            = 1'b0;
  logic                       rst            = 1'b1;
  logic                       cfg_valid      = 1'b0;
  logic                       cfg_ready;
  logic [CFG_INDEX_W-1:0]     cfg_index      = '0;
  logic [CFG_DATA_W-1:0]      cfg_data       = '0;
  logic                       in_valid       = 1'b0;
  logic                       in_ready;
  sample_t                    pixel_value    = '0;
  logic                       out_valid;
  logic                       out_ready      = 1'b0;
  logic signed [RESULT_W-1:0] filtered_value;
  logic [ROW_W-1:0]           out_row;
  logic [OUT_COL_W-1:0]       out_col;
  logic                       last_of_image;
  int                         mismatches;
  int                         results_due;
  logic                       at_image_start;

  int       burst_left = 0;
  int       random_fed = 0;
  rx_mode_t rx_mode    = RX_ALWAYS;
  int       rx_cnt     = 0;
  int       rx_hold    = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  conv3x3_replicate_border_core i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .pixel_value    (pixel_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .filtered_value (filtered_value),
    .out_row        (out_row),
    .out_col        (out_col),
    .last_of_image  (last_of_image)
  );

  conv3x3_result_checker u_result_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .pixel_value    (pixel_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .filtered_value (filtered_value),
    .out_row        (out_row),
    .out_col        (out_col),
    .last_of_image  (last_of_image),
    .mismatches     (mismatches),
    .results_due    (results_due),
    .at_image_start (at_image_start)
  );

  // The receiver switches at random between stall patterns.
  always @(negedge clk) begin
    if (rx_cnt == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_cnt  <= $urandom_range(40, 200);
    end else begin
      rx_cnt <= rx_cnt - 1;
    end
    case (rx_mode)
      RX_ALWAYS: out_ready <= 1'b1;
      RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RX_STALL_RUNS: begin
        if (rx_hold != 0) begin
          out_ready <= 1'b0;
          rx_hold   <= rx_hold - 1;
        end else if ($urandom_range(0, 9) == 0) begin
          out_ready <= 1'b0;
          rx_hold   <= $urandom_range(1, 12);
        end else begin
          out_ready <= 1'b1;
        end
      end
      default:   out_ready <= (rx_cnt[1:0] == 2'd0);
    endcase
  end

  // Random bits above the field show that the block ignores them.
  function automatic logic [CFG_DATA_W-1:0] pad_field(logic [CFG_DATA_W-1:0] v, int bits);
    logic [CFG_DATA_W-1:0] junk;
    junk = {$urandom, $urandom};
    return (junk << bits) | (v & ((64'd1 << bits) - 64'd1));
  endfunction

  function automatic sample_t rand_pixel();
    case ($urandom_range(0, 9))
      0:       return PIX_MAX;
      1:       return PIX_MIN;
      2:       return '0;
      3:       return -16'sd1;
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic kernel_t centered(coeff_t v);
    kernel_t k;
    k    = '{default: '0};
    k[4] = v;
    return k;
  endfunction

  function automatic kernel_t random_kernel();
    kernel_t k;
    for (int i = 0; i < TAPS; i++) begin
      case ($urandom_range(0, 5))
        0:       k[i] = TAP_MAX;
        1:       k[i] = TAP_MIN;
        default: k[i] = coeff_t'($urandom);
      endcase
    end
    return k;
  endfunction

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_geometry(int unsigned w, int unsigned h);
    write_reg(REG_IMAGE_WIDTH, pad_field(64'(w), IMG_WIDTH_W));
    write_reg(REG_IMAGE_HEIGHT, pad_field(64'(h), IMG_HEIGHT_W));
  endtask

  task automatic load_kernel(kernel_t k);
    write_reg(REG_COEFFS_LOW, {k[3], k[2], k[1], k[0]});
    write_reg(REG_COEFFS_MID, {k[7], k[6], k[5], k[4]});
    write_reg(REG_COEFF_LAST, pad_field(64'(k[8]), COEFF_W));
  endtask

  // Sends one pixel in bursts with random gaps; returns at the falling edge after the transfer.
  task automatic push_pixel(sample_t v);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? 64 : $urandom_range(1, 24);
      gap        = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid    <= 1'b1;
    pixel_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic feed(int count);
    repeat (count) push_pixel(rand_pixel());
  endtask

  // Lets all results drain, then keeps waiting so that items that made none also pass through.
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (results_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    int unsigned w;
    int unsigned h;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // One-pixel images: identity kernel, then a half tap to hit rounding ties.
    set_geometry(1, 1);
    load_kernel(centered(TAP_ONE));
    push_pixel(PIX_MAX);
    push_pixel(PIX_MIN);
    push_pixel('0);
    push_pixel(-16'sd1);
    settle();
    load_kernel(centered(TAP_HALF));
    push_pixel(16'sd1);
    push_pixel(-16'sd1);
    push_pixel(16'sd3);
    push_pixel(-16'sd3);
    settle();

    // Largest positive sums: all taps and pixels at their maximum, then all at their minimum.
    set_geometry(3, 2);
    load_kernel('{TAPS{TAP_MAX}});
    repeat (6) push_pixel(PIX_MAX);
    settle();
    load_kernel('{TAPS{TAP_MIN}});
    repeat (6) push_pixel(PIX_MIN);
    settle();

    // A zero width acts as one column; a single-row image.
    set_geometry(0, 3);
    load_kernel(random_kernel());
    feed(3);
    settle();
    write_reg(SPARE_REG_INDEX, {$urandom, $urandom});
    set_geometry(2, 1);
    feed(2);
    settle();

    // An oversized width keeps the row open; a zero height acts as one row.
    // A width of one written mid-row then closes the row at the next pixel.
    set_geometry(11'h7FF, 0);
    load_kernel(random_kernel());
    feed(WIDE_ROW_PIXELS);
    settle();
    write_reg(REG_IMAGE_WIDTH, pad_field(64'd1, IMG_WIDTH_W));
    push_pixel(rand_pixel());
    settle();

    while (random_fed < RANDOM_PIXELS) begin
      w = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      load_kernel(random_kernel());
      if ($urandom_range(0, 9) == 0) begin
        write_reg(SPARE_REG_INDEX, {$urandom, $urandom});
      end
      if ($urandom_range(0, 4) == 0) begin
        // Tall image cut short by shrinking height and maybe width, often mid-row.
        set_geometry(w, $urandom_range(16'h8000, 16'hFFFF));
        h = w * $urandom_range(1, 3) + $urandom_range(0, w - 1);
        feed(h);
        random_fed += h;
        settle();
        if ($urandom_range(0, 1) == 1) begin
          write_reg(REG_IMAGE_WIDTH, pad_field(64'($urandom_range(0, w)), IMG_WIDTH_W));
        end
        write_reg(REG_IMAGE_HEIGHT, pad_field(64'($urandom_range(0, 1)), IMG_HEIGHT_W));
        while (!at_image_start) begin
          push_pixel(rand_pixel());
          random_fed++;
        end
      end else begin
        h = $urandom_range(1, 6);
        set_geometry(w, h);
        if (w > 8) begin
          feed(w * h);
          random_fed += w * h;
        end else begin
          h = h * $urandom_range(1, 2);
          feed(w * h);
          random_fed += w * h;
        end
      end
      settle();
    end

    if (mismatches == 0 && results_due == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/c3rb_pkg.sv
rtl/core/c3rb_line_mem.sv
rtl/core/c3rb_mac.sv
rtl/core/c3rb_out_fifo.sv
rtl/core/conv3x3_replicate_border_core.sv
rtl/core/c3rb_checker.sv
dv/conv3x3_result_checker.sv
dv/tb_conv3x3_replicate_border_core.sv
